### hw/rtl/yrgb_pkg.sv
`timescale 1ns / 1ps

package yrgb_pkg;

   localparam int IdxW   = 13;
   localparam int PixW   = 8;
   localparam int CoefW  = 10;
   localparam int NumCoef = 5;
   localparam int ProdW  = PixW + CoefW;
   localparam int SumW   = ProdW + 2;
   localparam int OffW   = 16;
   localparam int WidthQW = 7;
   localparam int DivW   = IdxW - 3;
   localparam int TileW  = 3;
   localparam int DataW  = CoefW * NumCoef;
   localparam int CsrIdxW = 3;
   localparam int BytesW = 32;
   localparam int CountW = 3;

   localparam int COEF_Y  = 0;
   localparam int COEF_VR = 1;
   localparam int COEF_VG = 2;
   localparam int COEF_UG = 3;
   localparam int COEF_UB = 4;

   typedef enum logic [1:0] {
      FMT_RGBA8  = 2'd0,
      FMT_RGB8   = 2'd1,
      FMT_RGB5A1 = 2'd2,
      FMT_RGB565 = 2'd3
   } fmt_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_CONTROL      = 3'd0,
      CSR_LINE_WIDTH   = 3'd1,
      CSR_COEFFICIENTS = 3'd2,
      CSR_RED_OFFSET   = 3'd3,
      CSR_GREEN_OFFSET = 3'd4,
      CSR_BLUE_OFFSET  = 3'd5,
      CSR_ALPHA_VALUE  = 3'd6,
      CSR_UNUSED       = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic                   swizzle;
      fmt_type                fmt;
      logic [WidthQW-1:0]     width_q;
      logic [DataW-1:0]       coef;
      logic signed [OffW-1:0] red_off;
      logic signed [OffW-1:0] green_off;
      logic signed [OffW-1:0] blue_off;
      logic [PixW-1:0]        alpha;
   } csr_type;

   // everything zero except a line width of eight
   localparam csr_type CsrReset = '{
      swizzle:   1'b0,
      fmt:       FMT_RGBA8,
      width_q:   WidthQW'(1),
      coef:      '0,
      red_off:   '0,
      green_off: '0,
      blue_off:  '0,
      alpha:     '0
   };

   typedef struct packed {
      logic               q;
      logic [WidthQW-1:0] rem;
   } div_step_type;

   // one restoring division step: shift in a dividend bit, subtract if it fits
   function automatic div_step_type div_step(input logic [WidthQW-1:0] rem,
                                             input logic din,
                                             input logic [WidthQW-1:0] d);
      logic [WidthQW:0] trial;
      logic [WidthQW:0] diff;
      div_step_type     res;
      trial = {rem, din};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         res.q   = 1'b1;
         res.rem = diff[WidthQW-1:0];
      end else begin
         res.q   = 1'b0;
         res.rem = trial[WidthQW-1:0];
      end
      return res;
   endfunction

endpackage

### hw/rtl/yrgb_divider.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: (pixel_index div 8) by (line_width div 8).
// Three stages of 4, 3 and 3 steps; only the low quotient bits are kept.
module yrgb_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [yrgb_pkg::IdxW-1:0]          in_idx,
   input  logic [yrgb_pkg::WidthQW-1:0]       width_q,
   output logic                               out_valid,
   output logic [yrgb_pkg::IdxW-1:0]          out_idx,
   output logic [yrgb_pkg::WidthQW-1:0]       out_rem,
   output logic [yrgb_pkg::TileW-1:0]         out_quot
);

   localparam int StepsA = 4;
   localparam int StepsB = 3;
   localparam int StepsC = yrgb_pkg::DivW - StepsA - StepsB;

   logic                          valid_a_ff, valid_b_ff, valid_c_ff;
   logic [yrgb_pkg::IdxW-1:0]     idx_a_ff, idx_b_ff, idx_c_ff;
   logic [yrgb_pkg::WidthQW-1:0]  rem_a_ff, rem_b_ff, rem_c_ff;
   logic [yrgb_pkg::WidthQW-1:0]  rem_a_in, rem_b_in, rem_c_in;
   logic [yrgb_pkg::TileW-1:0]    quot_c_ff, quot_c_in;

   always_comb begin
      logic [yrgb_pkg::DivW-1:0]    dvd;
      logic [yrgb_pkg::WidthQW-1:0] rem;
      yrgb_pkg::div_step_type       st;
      dvd = in_idx[yrgb_pkg::IdxW-1:3];
      rem = '0;
      for (int i = 0; i < StepsA; i++) begin
         st  = yrgb_pkg::div_step(rem, dvd[yrgb_pkg::DivW-1-i], width_q);
         rem = st.rem;
      end
      rem_a_in = rem;
   end

   always_comb begin
      logic [yrgb_pkg::DivW-1:0]    dvd;
      logic [yrgb_pkg::WidthQW-1:0] rem;
      yrgb_pkg::div_step_type       st;
      dvd = idx_a_ff[yrgb_pkg::IdxW-1:3];
      rem = rem_a_ff;
      for (int i = 0; i < StepsB; i++) begin
         st  = yrgb_pkg::div_step(rem, dvd[yrgb_pkg::DivW-1-StepsA-i], width_q);
         rem = st.rem;
      end
      rem_b_in = rem;
   end

   always_comb begin
      logic [yrgb_pkg::DivW-1:0]    dvd;
      logic [yrgb_pkg::WidthQW-1:0] rem;
      yrgb_pkg::div_step_type       st;
      dvd       = idx_b_ff[yrgb_pkg::IdxW-1:3];
      rem       = rem_b_ff;
      quot_c_in = '0;
      for (int i = 0; i < StepsC; i++) begin
         st  = yrgb_pkg::div_step(rem, dvd[StepsC-1-i], width_q);
         rem = st.rem;
         quot_c_in[StepsC-1-i] = st.q;
      end
      rem_c_in = rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_a_ff  <= in_idx;
      idx_b_ff  <= idx_a_ff;
      idx_c_ff  <= idx_b_ff;
      rem_a_ff  <= rem_a_in;
      rem_b_ff  <= rem_b_in;
      rem_c_ff  <= rem_c_in;
      quot_c_ff <= quot_c_in;
   end

   assign out_valid = valid_c_ff;
   assign out_idx   = idx_c_ff;
   assign out_rem   = rem_c_ff;
   assign out_quot  = quot_c_ff;

endmodule

### hw/rtl/yrgb_color.sv
`timescale 1ns / 1ps

// Color matrix: products, then sums with offset, then shift and clamp.
module yrgb_color (
   input  logic                         clock,
   input  logic [yrgb_pkg::PixW-1:0]    luma,
   input  logic [yrgb_pkg::PixW-1:0]    chroma_u,
   input  logic [yrgb_pkg::PixW-1:0]    chroma_v,
   input  yrgb_pkg::csr_type            csr,
   output logic [yrgb_pkg::PixW-1:0]    red,
   output logic [yrgb_pkg::PixW-1:0]    green,
   output logic [yrgb_pkg::PixW-1:0]    blue
);

   localparam int ShW   = yrgb_pkg::SumW - 3;
   localparam int BiasW = ShW + 1;
   localparam int OutW  = BiasW - 5;

   logic [yrgb_pkg::ProdW-1:0] py_ff, pvr_ff, pvg_ff, pug_ff, pub_ff;
   logic [yrgb_pkg::ProdW-1:0] py_in, pvr_in, pvg_in, pug_in, pub_in;
   logic signed [BiasW-1:0]    br_ff, bg_ff, bb_ff;
   logic signed [BiasW-1:0]    br_in, bg_in, bb_in;
   logic [yrgb_pkg::PixW-1:0]  r_ff, g_ff, b_ff;

   function automatic logic [yrgb_pkg::ProdW-1:0] mul(input logic [yrgb_pkg::PixW-1:0] a,
                                                      input logic [yrgb_pkg::CoefW-1:0] c);
      return yrgb_pkg::ProdW'(a) * yrgb_pkg::ProdW'(c);
   endfunction

   // sum >>> 3, then add the sign-extended offset
   function automatic logic signed [BiasW-1:0] bias(input logic signed [yrgb_pkg::SumW-1:0] s,
                                                    input logic signed [yrgb_pkg::OffW-1:0] o);
      logic signed [ShW-1:0] sh;
      sh = s[yrgb_pkg::SumW-1:3];
      return BiasW'(sh) + BiasW'(o);
   endfunction

   function automatic logic [yrgb_pkg::PixW-1:0] clamp(input logic signed [BiasW-1:0] b);
      logic [OutW-1:0] v;
      v = b[BiasW-1:5];
      if (v[OutW-1]) begin
         return '0;
      end else if (|v[OutW-2:yrgb_pkg::PixW]) begin
         return '1;
      end
      return v[yrgb_pkg::PixW-1:0];
   endfunction

   function automatic logic [yrgb_pkg::CoefW-1:0] coef(input logic [yrgb_pkg::DataW-1:0] c,
                                                       input int k);
      return c[k*yrgb_pkg::CoefW +: yrgb_pkg::CoefW];
   endfunction

   always_comb begin
      py_in  = mul(luma,     coef(csr.coef, yrgb_pkg::COEF_Y));
      pvr_in = mul(chroma_v, coef(csr.coef, yrgb_pkg::COEF_VR));
      pvg_in = mul(chroma_v, coef(csr.coef, yrgb_pkg::COEF_VG));
      pug_in = mul(chroma_u, coef(csr.coef, yrgb_pkg::COEF_UG));
      pub_in = mul(chroma_u, coef(csr.coef, yrgb_pkg::COEF_UB));
   end

   always_comb begin
      logic signed [yrgb_pkg::SumW-1:0] sr, sg, sb;
      sr = signed'(yrgb_pkg::SumW'(py_ff)) + signed'(yrgb_pkg::SumW'(pvr_ff));
      sg = signed'(yrgb_pkg::SumW'(py_ff)) - signed'(yrgb_pkg::SumW'(pvg_ff))
         - signed'(yrgb_pkg::SumW'(pug_ff));
      sb = signed'(yrgb_pkg::SumW'(py_ff)) + signed'(yrgb_pkg::SumW'(pub_ff));
      br_in = bias(sr, csr.red_off);
      bg_in = bias(sg, csr.green_off);
      bb_in = bias(sb, csr.blue_off);
   end

   always_ff @(posedge clock) begin
      py_ff  <= py_in;
      pvr_ff <= pvr_in;
      pvg_ff <= pvg_in;
      pug_ff <= pug_in;
      pub_ff <= pub_in;
      br_ff  <= br_in;
      bg_ff  <= bg_in;
      bb_ff  <= bb_in;
      r_ff   <= clamp(br_ff);
      g_ff   <= clamp(bg_ff);
      b_ff   <= clamp(bb_ff);
   end

   assign red   = r_ff;
   assign green = g_ff;
   assign blue  = b_ff;

endmodule

### hw/rtl/yuv_to_rgb_pixel_converter.sv
`timescale 1ns / 1ps

// Channel   Ports                                        Handshake
// request   req_pixel_index, req_luma, req_chroma_u/v    start && !busy
// response  rsp_buffer_address, rsp_pixel_bytes,         rsp_valid, one cycle
//           rsp_byte_count, rsp_strip_done, rsp_index_error
// csr       csr_index, csr_wr_data                       csr_wr_en
//
// One pixel per cycle; each transaction appears on rsp_* once it has passed the
// divider (three stages) and the packing register.
// busy is never raised: the receiver cannot stall, so nothing backs up.
// Synchronous reset loads the csr registers with their reset values and clears all valid bits.
module yuv_to_rgb_pixel_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [yrgb_pkg::IdxW-1:0]           req_pixel_index,
   input  logic [yrgb_pkg::PixW-1:0]           req_luma,
   input  logic [yrgb_pkg::PixW-1:0]           req_chroma_u,
   input  logic [yrgb_pkg::PixW-1:0]           req_chroma_v,
   output logic                                rsp_valid,
   output logic [yrgb_pkg::IdxW-1:0]           rsp_buffer_address,
   output logic [yrgb_pkg::BytesW-1:0]         rsp_pixel_bytes,
   output logic [yrgb_pkg::CountW-1:0]         rsp_byte_count,
   output logic                                rsp_strip_done,
   output logic                                rsp_index_error,
   input  logic                                csr_wr_en,
   input  logic [yrgb_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [yrgb_pkg::DataW-1:0]          csr_wr_data
);

   yrgb_pkg::csr_type csr_ff, csr_in;

   logic                          div_valid;
   logic [yrgb_pkg::IdxW-1:0]     div_idx;
   logic [yrgb_pkg::WidthQW-1:0]  div_rem;
   logic [yrgb_pkg::TileW-1:0]    div_quot;
   logic [yrgb_pkg::PixW-1:0]     red, green, blue;

   logic                          valid_ff;
   logic [yrgb_pkg::IdxW-1:0]     addr_ff, addr_in;
   logic [yrgb_pkg::BytesW-1:0]   bytes_ff, bytes_in;
   logic [yrgb_pkg::CountW-1:0]   count_ff, count_in;
   logic                          done_ff, done_in;
   logic                          err_ff, err_in;

   assign busy = 1'b0;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (yrgb_pkg::csr_idx_type'(csr_index))
            yrgb_pkg::CSR_CONTROL: begin
               csr_in.fmt     = yrgb_pkg::fmt_type'(csr_wr_data[1:0]);
               csr_in.swizzle = csr_wr_data[2];
            end
            yrgb_pkg::CSR_LINE_WIDTH:   csr_in.width_q = csr_wr_data[9:3];
            yrgb_pkg::CSR_COEFFICIENTS: csr_in.coef = csr_wr_data;
            yrgb_pkg::CSR_RED_OFFSET:   csr_in.red_off = csr_wr_data[yrgb_pkg::OffW-1:0];
            yrgb_pkg::CSR_GREEN_OFFSET: csr_in.green_off = csr_wr_data[yrgb_pkg::OffW-1:0];
            yrgb_pkg::CSR_BLUE_OFFSET:  csr_in.blue_off = csr_wr_data[yrgb_pkg::OffW-1:0];
            yrgb_pkg::CSR_ALPHA_VALUE:  csr_in.alpha = csr_wr_data[yrgb_pkg::PixW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= yrgb_pkg::CsrReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   yrgb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_idx    (req_pixel_index),
      .width_q   (csr_ff.width_q),
      .out_valid (div_valid),
      .out_idx   (div_idx),
      .out_rem   (div_rem),
      .out_quot  (div_quot)
   );

   yrgb_color u_color (
      .clock    (clock),
      .luma     (req_luma),
      .chroma_u (req_chroma_u),
      .chroma_v (req_chroma_v),
      .csr      (csr_ff),
      .red      (red),
      .green    (green),
      .blue     (blue)
   );

   // address swizzle, strip flags and byte packing
   always_comb begin
      logic [yrgb_pkg::WidthQW-1:0] col;
      logic [yrgb_pkg::TileW-1:0]   row;
      logic [yrgb_pkg::IdxW-1:0]    total;
      logic [yrgb_pkg::IdxW-1:0]    last;
      logic [yrgb_pkg::WidthQW-1:0] wq_m1;
      logic                         zero_w;
      zero_w = (csr_ff.width_q == '0);
      // zero width: column is index bits 9:3, row is zero
      col    = zero_w ? div_idx[9:3] : div_rem;
      row    = zero_w ? '0 : div_quot;
      wq_m1  = csr_ff.width_q - yrgb_pkg::WidthQW'(1);
      total  = {csr_ff.width_q, 6'b0};
      last   = {wq_m1, 6'h3F};
      if (csr_ff.swizzle) begin
         addr_in = {col, row[2], div_idx[2], row[1], div_idx[1], row[0], div_idx[0]};
      end else begin
         addr_in = div_idx;
      end
      done_in = !zero_w && (addr_in == last);
      err_in  = (div_idx >= total);

      case (csr_ff.fmt)
         yrgb_pkg::FMT_RGBA8: begin
            bytes_in = {red, green, blue, csr_ff.alpha};
            count_in = yrgb_pkg::CountW'(4);
         end
         yrgb_pkg::FMT_RGB8: begin
            bytes_in = {8'h00, red, green, blue};
            count_in = yrgb_pkg::CountW'(3);
         end
         yrgb_pkg::FMT_RGB5A1: begin
            bytes_in = {16'h0000, red[7:3], green[7:3], blue[7:3], csr_ff.alpha[7]};
            count_in = yrgb_pkg::CountW'(2);
         end
         default: begin
            bytes_in = {16'h0000, red[7:3], green[7:2], blue[7:3]};
            count_in = yrgb_pkg::CountW'(2);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      bytes_ff <= bytes_in;
      count_ff <= count_in;
      done_ff  <= done_in;
      err_ff   <= err_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_buffer_address = addr_ff;
   assign rsp_pixel_bytes    = bytes_ff;
   assign rsp_byte_count     = count_ff;
   assign rsp_strip_done     = done_ff;
   assign rsp_index_error    = err_ff;

endmodule
